FILE: hw/rtl/spi_pkg.sv
package spi_pkg;

  localparam int DIV_W = 16;
  localparam int POS_W = 16;
  localparam logic [15:0] CENTRE_POS = 16'd512;

  localparam logic [7:0] HDR_BYTE  = 8'hFF;
  localparam logic [7:0] BCAST_ID  = 8'hFE;
  localparam logic [7:0] PARAM_LEN = 8'd2;

  localparam logic [2:0] OP_SET_ID  = 3'd0;
  localparam logic [2:0] OP_SET_TGT = 3'd1;
  localparam logic [2:0] OP_START   = 3'd2;
  localparam logic [2:0] OP_TICK    = 3'd3;
  localparam logic [2:0] OP_SET_CUR = 3'd4;

  localparam logic [1:0] REG_COUNT = 2'd0;
  localparam logic [1:0] REG_INSTR = 2'd1;
  localparam logic [1:0] REG_GOAL  = 2'd2;

  localparam logic [4:0] COUNT_RST = 5'd0;
  localparam logic [7:0] INSTR_RST = 8'd131;
  localparam logic [7:0] GOAL_RST  = 8'd30;

  typedef enum logic [3:0] {
    SEL_FF0, SEL_FF1, SEL_FE, SEL_LEN, SEL_INS, SEL_REG, SEL_TWO,
    SEL_ID, SEL_LO, SEL_HI, SEL_CSUM
  } sel_t;

  typedef struct packed {
    logic host_wr;
    logic frames_load;
    logic div_step;
    logic step_load;
    logic tick_init;
    logic upd;
    logic fin;
    logic set_interp;
    logic emit;
    sel_t sel;
  } cmd_t;

  typedef struct packed {
    logic div_done;
    logic interp;
    logic out_free;
  } status_t;

endpackage

FILE: hw/rtl/spi_if.sv
interface spi_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  op;
  logic [3:0]  slot;
  logic [7:0]  servo_id;
  logic [11:0] position;
  logic [14:0] duration_ms;
  modport source (output valid, op, slot, servo_id, position, duration_ms, input ready);
  modport sink (input valid, op, slot, servo_id, position, duration_ms, output ready);
endinterface

interface spi_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] tx_byte;
  logic       last_byte;
  logic       moving;
  modport source (output valid, tx_byte, last_byte, moving, input ready);
  modport sink (input valid, tx_byte, last_byte, moving, output ready);
endinterface

FILE: hw/rtl/spi_div.sv
module spi_div
  import spi_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             go,
  input  logic [DIV_W-1:0] dividend,
  input  logic [DIV_W-1:0] divisor,
  output logic             done,
  output logic [DIV_W-1:0] quot
);

  localparam int CNT_W = $clog2(DIV_W + 1);

  logic [DIV_W:0]   rem_r, rem_nxt;
  logic [DIV_W-1:0] quo_r, quo_nxt;
  logic [DIV_W-1:0] dsr_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r, done_r;
  logic [DIV_W:0]   trial;

  always_comb begin
    trial = {rem_r[DIV_W-1:0], quo_r[DIV_W-1]};
    quo_nxt = {quo_r[DIV_W-2:0], 1'b0};
    rem_nxt = trial;
    if (trial >= {1'b0, dsr_r}) begin
      rem_nxt = trial - {1'b0, dsr_r};
      quo_nxt[0] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (go) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(DIV_W);
        rem_r  <= '0;
        quo_r  <= dividend;
        dsr_r  <= divisor;
      end else if (busy_r) begin
        rem_r <= rem_nxt;
        quo_r <= quo_nxt;
        cnt_r <= cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign quot = quo_r;

endmodule

FILE: hw/rtl/spi_ctrl.sv
module spi_ctrl
  import spi_pkg::*;
#(
  parameter int MAX_SERVOS = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  input  logic [2:0]                     op,
  input  logic [$clog2(MAX_SERVOS+1)-1:0] n,
  input  status_t                        stat,
  output logic                           in_ready,
  output cmd_t                           cmd,
  output logic [((MAX_SERVOS>1)?$clog2(MAX_SERVOS):1)-1:0] idx
);

  localparam int CW = $clog2(MAX_SERVOS + 1);
  localparam int IW = (MAX_SERVOS > 1) ? $clog2(MAX_SERVOS) : 1;

  typedef enum logic [2:0] {
    S_IDLE, S_SGO, S_SDIV, S_UPD, S_FIN, S_EMIT
  } state_t;

  state_t        state_r, state_nxt;
  sel_t          sel_r, sel_nxt;
  logic [IW-1:0] idx_r, idx_nxt;
  logic          last_slot;

  assign last_slot = (CW'(idx_r) == n - CW'(1));
  assign in_ready  = (state_r == S_IDLE);

  always_comb begin
    cmd       = '0;
    cmd.sel   = sel_r;
    state_nxt = state_r;
    sel_nxt   = sel_r;
    idx_nxt   = idx_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.host_wr = 1'b1;
          priority case (op)
            OP_START: begin
              cmd.frames_load = 1'b1;
              idx_nxt         = '0;
              if (n == '0) begin
                cmd.set_interp = 1'b1;
              end else begin
                state_nxt = S_SGO;
              end
            end
            OP_TICK: begin
              if (stat.interp) begin
                cmd.tick_init = 1'b1;
                idx_nxt       = '0;
                state_nxt     = (n == '0) ? S_FIN : S_UPD;
              end
            end
            default: ;
          endcase
        end
      end
      S_SGO: begin
        cmd.div_step = 1'b1;
        state_nxt    = S_SDIV;
      end
      S_SDIV: begin
        if (stat.div_done) begin
          cmd.step_load = 1'b1;
          if (last_slot) begin
            cmd.set_interp = 1'b1;
            state_nxt      = S_IDLE;
          end else begin
            idx_nxt   = idx_r + IW'(1);
            state_nxt = S_SGO;
          end
        end
      end
      S_UPD: begin
        cmd.upd = 1'b1;
        if (last_slot) begin
          state_nxt = S_FIN;
        end else begin
          idx_nxt = idx_r + IW'(1);
        end
      end
      S_FIN: begin
        cmd.fin   = 1'b1;
        sel_nxt   = SEL_FF0;
        idx_nxt   = '0;
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (stat.out_free) begin
          cmd.emit = 1'b1;
          unique case (sel_r)
            SEL_FF0: sel_nxt = SEL_FF1;
            SEL_FF1: sel_nxt = SEL_FE;
            SEL_FE:  sel_nxt = SEL_LEN;
            SEL_LEN: sel_nxt = SEL_INS;
            SEL_INS: sel_nxt = SEL_REG;
            SEL_REG: sel_nxt = SEL_TWO;
            SEL_TWO: sel_nxt = (n == '0) ? SEL_CSUM : SEL_ID;
            SEL_ID:  sel_nxt = SEL_LO;
            SEL_LO:  sel_nxt = SEL_HI;
            SEL_HI: begin
              if (last_slot) begin
                sel_nxt = SEL_CSUM;
              end else begin
                sel_nxt = SEL_ID;
                idx_nxt = idx_r + IW'(1);
              end
            end
            SEL_CSUM: state_nxt = S_IDLE;
            default:  state_nxt = S_IDLE;
          endcase
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      sel_r   <= SEL_FF0;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      sel_r   <= sel_nxt;
      idx_r   <= idx_nxt;
    end
  end

  assign idx = idx_r;

endmodule

FILE: hw/rtl/spi_dp.sv
module spi_dp
  import spi_pkg::*;
#(
  parameter int MAX_SERVOS     = 16,
  parameter int POSITION_SHIFT = 3,
  parameter int FRAME_MS       = 33
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  cmd_t                            cmd,
  input  logic [((MAX_SERVOS>1)?$clog2(MAX_SERVOS):1)-1:0] idx,
  input  logic [$clog2(MAX_SERVOS+1)-1:0] n,
  input  logic [2:0]                      op,
  input  logic [3:0]                      slot,
  input  logic [7:0]                      servo_id,
  input  logic [11:0]                     position,
  input  logic [14:0]                     duration_ms,
  input  logic [7:0]                      instr,
  input  logic [7:0]                      goal,
  input  logic                            out_ready,
  output status_t                         stat,
  output logic                            out_valid,
  output logic [7:0]                      tx_byte,
  output logic                            last_byte,
  output logic                            moving
);

  localparam int CW = $clog2(MAX_SERVOS + 1);
  localparam int IW = (MAX_SERVOS > 1) ? $clog2(MAX_SERVOS) : 1;

  // frame count by reciprocal multiply, exact for 15-bit durations
  localparam int FR_SH = 15 + $clog2(FRAME_MS);
  localparam logic [16:0] FR_MUL =
    17'(((64'd1 << FR_SH) + 64'(FRAME_MS) - 64'd1) / 64'(FRAME_MS));

  logic [7:0]       ids_r  [MAX_SERVOS];
  logic [POS_W-1:0] cur_r  [MAX_SERVOS];
  logic [POS_W-1:0] tgt_r  [MAX_SERVOS];
  logic [POS_W-1:0] step_r [MAX_SERVOS];

  logic [DIV_W-1:0] frames_r;
  logic [CW-1:0]    done_r;
  logic             interp_r;
  logic [7:0]       sum_r;
  logic             oval_r, olast_r, omov_r;
  logic [7:0]       obyte_r;

  logic             slot_ok;
  logic [IW-1:0]    widx;
  logic [POS_W-1:0] cur, tgt, st, gap, cur_nxt, pos_s, wpos;
  logic             slot_done;
  logic             div_go, div_done;
  logic [DIV_W-1:0] div_a, div_b, quot;
  logic [31:0]      fr_prod;
  logic [DIV_W-1:0] frames_c;
  logic [7:0]       byte_c, len;

  assign slot_ok = (5'(slot) < 5'(MAX_SERVOS));
  assign widx    = IW'(slot);
  assign wpos    = POS_W'(position) << POSITION_SHIFT;

  assign cur = cur_r[idx];
  assign tgt = tgt_r[idx];
  assign st  = step_r[idx];
  assign gap = (tgt > cur) ? (tgt - cur) : (cur - tgt);

  always_comb begin
    cur_nxt   = cur;
    slot_done = 1'b0;
    if (cur == tgt) begin
      slot_done = 1'b1;
    end else if (gap < st) begin
      cur_nxt   = tgt;
      slot_done = 1'b1;
    end else if (tgt > cur) begin
      cur_nxt = cur + st;
    end else begin
      cur_nxt = cur - st;
    end
  end

  assign fr_prod  = 32'(duration_ms) * 32'(FR_MUL);
  assign frames_c = DIV_W'(fr_prod >> FR_SH) + DIV_W'(1);

  assign div_go = cmd.div_step;
  assign div_a  = gap;
  assign div_b  = frames_r;

  spi_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .go       (div_go),
    .dividend (div_a),
    .divisor  (div_b),
    .done     (div_done),
    .quot     (quot)
  );

  assign pos_s = cur >> POSITION_SHIFT;
  assign len   = 8'd4 + 8'(n) * 8'd3;

  always_comb begin
    unique case (cmd.sel)
      SEL_FF0:  byte_c = HDR_BYTE;
      SEL_FF1:  byte_c = HDR_BYTE;
      SEL_FE:   byte_c = BCAST_ID;
      SEL_LEN:  byte_c = len;
      SEL_INS:  byte_c = instr;
      SEL_REG:  byte_c = goal;
      SEL_TWO:  byte_c = PARAM_LEN;
      SEL_ID:   byte_c = ids_r[idx];
      SEL_LO:   byte_c = pos_s[7:0];
      SEL_HI:   byte_c = pos_s[15:8];
      SEL_CSUM: byte_c = ~sum_r;
      default:  byte_c = ~sum_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MAX_SERVOS; i++) begin
        ids_r[i] <= 8'(i + 1);
        cur_r[i] <= CENTRE_POS << POSITION_SHIFT;
        tgt_r[i] <= CENTRE_POS << POSITION_SHIFT;
      end
    end else begin
      if (cmd.host_wr && slot_ok) begin
        priority case (op)
          OP_SET_ID:  ids_r[widx] <= servo_id;
          OP_SET_TGT: tgt_r[widx] <= wpos;
          OP_SET_CUR: cur_r[widx] <= wpos;
          default: ;
        endcase
      end
      if (cmd.upd) begin
        cur_r[idx] <= cur_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.step_load) begin
      step_r[idx] <= quot + DIV_W'(1);
    end
    if (cmd.frames_load) begin
      frames_r <= frames_c;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      interp_r <= 1'b0;
      done_r   <= '0;
      sum_r    <= '0;
      oval_r   <= 1'b0;
    end else begin
      if (cmd.set_interp) begin
        interp_r <= 1'b1;
      end
      if (cmd.tick_init) begin
        done_r <= '0;
      end else if (cmd.upd && slot_done) begin
        done_r <= done_r + CW'(1);
      end
      if (cmd.fin) begin
        sum_r <= '0;
        if (done_r >= n) begin
          interp_r <= 1'b0;
        end
      end
      if (cmd.emit) begin
        oval_r  <= 1'b1;
        obyte_r <= byte_c;
        olast_r <= (cmd.sel == SEL_CSUM);
        omov_r  <= interp_r;
        if (cmd.sel != SEL_FF0 && cmd.sel != SEL_FF1 && cmd.sel != SEL_CSUM) begin
          sum_r <= sum_r + byte_c;
        end
      end else if (out_ready) begin
        oval_r <= 1'b0;
      end
    end
  end

  assign stat.div_done = div_done;
  assign stat.interp   = interp_r;
  assign stat.out_free = !oval_r || out_ready;

  assign out_valid = oval_r;
  assign tx_byte   = obyte_r;
  assign last_byte = olast_r;
  assign moving    = omov_r;

endmodule

FILE: hw/rtl/servo_pose_interpolator.sv
// servo pose interpolator with sync-write packet output
// in_ch carries one command item: set id, set target, set current, start or
// frame tick. out_ch carries one packet byte per item, with last_byte on the
// checksum and moving giving the interpolation flag after the frame.
// set id, target and current are written as the item is accepted.
// start takes the frame count from a reciprocal multiply as the item is
// accepted, then one iterative divider, one quotient bit a cycle, gives
// each of the n active slots its step in turn.
// a frame tick while moving updates the slots one at a time, then emits
// 8 + 3*n bytes at one byte per cycle while the receiver takes them;
// no item is accepted until the checksum is in the output register.
// a stalled receiver holds the output register and pauses the byte stream.
// reset puts ids at slot index plus one, all poses at centre and
// interpolation off; registers are written over the apb port at 4*index.
module servo_pose_interpolator
  import spi_pkg::*;
#(
  parameter int MAX_SERVOS     = 16,
  parameter int POSITION_SHIFT = 3,
  parameter int FRAME_MS       = 33
) (
  input  logic        clk,
  input  logic        rst_n,
  spi_in_if.sink      in_ch,
  spi_out_if.source   out_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int CW = $clog2(MAX_SERVOS + 1);
  localparam int IW = (MAX_SERVOS > 1) ? $clog2(MAX_SERVOS) : 1;

  logic [4:0]    count_r;
  logic [7:0]    instr_r, goal_r;
  logic [CW-1:0] n;
  logic [IW-1:0] idx;
  cmd_t          cmd;
  status_t       stat;
  logic          wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= COUNT_RST;
      instr_r <= INSTR_RST;
      goal_r  <= GOAL_RST;
    end else if (wr_en) begin
      priority case (paddr[3:2])
        REG_COUNT: count_r <= pwdata[4:0];
        REG_INSTR: instr_r <= pwdata[7:0];
        REG_GOAL:  goal_r  <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    priority case (paddr[3:2])
      REG_COUNT: prdata = 32'(count_r);
      REG_INSTR: prdata = 32'(instr_r);
      REG_GOAL:  prdata = 32'(goal_r);
      default:   prdata = '0;
    endcase
  end

  assign n = (count_r < 5'(MAX_SERVOS)) ? count_r[CW-1:0] : CW'(MAX_SERVOS);

  spi_ctrl #(.MAX_SERVOS(MAX_SERVOS)) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .op       (in_ch.op),
    .n        (n),
    .stat     (stat),
    .in_ready (in_ch.ready),
    .cmd      (cmd),
    .idx      (idx)
  );

  spi_dp #(
    .MAX_SERVOS     (MAX_SERVOS),
    .POSITION_SHIFT (POSITION_SHIFT),
    .FRAME_MS       (FRAME_MS)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .idx         (idx),
    .n           (n),
    .op          (in_ch.op),
    .slot        (in_ch.slot),
    .servo_id    (in_ch.servo_id),
    .position    (in_ch.position),
    .duration_ms (in_ch.duration_ms),
    .instr       (instr_r),
    .goal        (goal_r),
    .out_ready   (out_ch.ready),
    .stat        (stat),
    .out_valid   (out_ch.valid),
    .tx_byte     (out_ch.tx_byte),
    .last_byte   (out_ch.last_byte),
    .moving      (out_ch.moving)
  );

endmodule

FILE: hw/rtl/spi_checker.sv
module spi_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] tx_byte,
  input logic       last_byte,
  input logic       moving
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(tx_byte))
    else $error("output byte dropped or changed under stall");

  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !last_byte |-> !in_ready)
    else $error("input taken in the middle of a packet");

  a_moving: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !last_byte |=> !out_valid || moving == $past(moving))
    else $error("moving flag changed within a packet");

  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind servo_pose_interpolator spi_checker u_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .tx_byte   (out_ch.tx_byte),
  .last_byte (out_ch.last_byte),
  .moving    (out_ch.moving)
);
